// ===== sv/baro_sensor_compensation_top_macros.svh =====
// Assertion macros for the barometric compensation block.
// Used by the checker module; expects signals clk and rst in scope.
`ifndef BARO_SENSOR_COMPENSATION_TOP_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_TOP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define BARO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BARO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/baro_pkg.sv =====
// Shared types, constants and the micro-program of the barometric compensation block.
// No dependencies; the controller, datapath, top-level and checker files import this package.
`default_nettype none

package baro_pkg;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  localparam logic [2:0] REG_COEF_LOW  = 3'd0;
  localparam logic [2:0] REG_COEF_MID  = 3'd1;
  localparam logic [2:0] REG_COEF_HIGH = 3'd2;
  localparam logic [2:0] REG_TEMP_SCL  = 3'd3;
  localparam logic [2:0] REG_PRES_SCL  = 3'd4;

  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;

  localparam logic [22:0] SCALE_RESET = 23'd524288;

  // Internal accumulator limit, 2^62 - 1.
  localparam logic signed [63:0] ACC_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic              op;
    logic signed [23:0] raw_sample;
  } in_beat_t;

  typedef struct packed {
    logic              result_kind;
    logic signed [47:0] compensated_value;
    logic              saturated;
  } out_beat_t;

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
  } coef_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_C30_SC,
    MS_SC_P,
    MS_C21_SC,
    MS_ST_SC,
    MS_M_X,
    MS_C01_SC,
    MS_C1_SC
  } mul_src_t;

  typedef enum logic [3:0] {
    AL_NONE,
    AL_TPT,
    AL_P_C0,
    AL_P_C20,
    AL_P_C10,
    AL_P_C00,
    AL_X_C11,
    AL_P_TPT_X_M,
    AL_P_X
  } alu_op_t;

  typedef struct packed {
    mul_src_t src;
    logic     shift;
    alu_op_t  alu;
    logic     last;
  } uop_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LOAD,
    S_RUN,
    S_ALU,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     sc_load;
    logic     mul_load;
    logic     mul_run;
    logic [1:0] mul_phase;
    mul_src_t mul_src;
    logic     mul_shift;
    logic     alu_en;
    alu_op_t  alu_op;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

  function automatic coef_t baro_coefs(input logic [63:0] lo, input logic [63:0] mid,
                                       input logic [15:0] hi);
    coef_t c;
    c.c0  = lo[63:52];
    c.c1  = lo[51:40];
    c.c00 = lo[39:20];
    c.c10 = lo[19:0];
    c.c01 = mid[63:48];
    c.c11 = mid[47:32];
    c.c20 = mid[31:16];
    c.c21 = mid[15:0];
    c.c30 = hi;
    return c;
  endfunction

  // One entry per step: optional multiply, then an optional add or store.
  function automatic uop_t baro_uop(input logic op, input logic [2:0] step);
    uop_t u;
    u = '{src: MS_NONE, shift: 1'b0, alu: AL_NONE, last: 1'b1};
    if (op == OP_TEMP) begin
      unique case (step)
        3'd0:    u = '{src: MS_C01_SC, shift: 1'b0, alu: AL_TPT,  last: 1'b0};
        default: u = '{src: MS_C1_SC,  shift: 1'b0, alu: AL_P_C0, last: 1'b1};
      endcase
    end else begin
      unique case (step)
        3'd0:    u = '{src: MS_C30_SC, shift: 1'b0, alu: AL_P_C20,     last: 1'b0};
        3'd1:    u = '{src: MS_SC_P,   shift: 1'b1, alu: AL_P_C10,     last: 1'b0};
        3'd2:    u = '{src: MS_SC_P,   shift: 1'b1, alu: AL_P_C00,     last: 1'b0};
        3'd3:    u = '{src: MS_C21_SC, shift: 1'b0, alu: AL_X_C11,     last: 1'b0};
        3'd4:    u = '{src: MS_ST_SC,  shift: 1'b1, alu: AL_NONE,      last: 1'b0};
        3'd5:    u = '{src: MS_M_X,    shift: 1'b1, alu: AL_P_TPT_X_M, last: 1'b0};
        default: u = '{src: MS_NONE,   shift: 1'b0, alu: AL_P_X,       last: 1'b1};
      endcase
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== sv/baro_ctrl.sv =====
// Sequencer of the barometric compensation block: divide, multiply/add steps, output.
// Depends on baro_pkg; drives the command struct of baro_dp.
`default_nettype none

module baro_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_op,
  input  wire baro_pkg::dp_stat_t stat,
  output      baro_pkg::ctl_cmd_t cmd,
  output      logic               in_stall
);
  import baro_pkg::*;

  state_t     state, state_next;
  logic [2:0] step, step_next;
  logic [1:0] phase, phase_next;
  logic       op_r;
  uop_t       uop;

  assign uop      = baro_uop(op_r, step);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      phase <= '0;
      op_r  <= OP_TEMP;
    end else begin
      state <= state_next;
      step  <= step_next;
      phase <= phase_next;
      if (state == S_IDLE && in_valid) begin
        op_r <= in_op;
      end
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_LOAD;
          step_next  = '0;
        end
      end
      S_LOAD: begin
        phase_next = '0;
        state_next = (uop.src == MS_NONE) ? S_ALU : S_RUN;
      end
      S_RUN: begin
        phase_next = phase + 2'd1;
        if (phase == 2'd3) begin
          state_next = S_ALU;
        end
      end
      S_ALU: begin
        if (uop.last) begin
          state_next = S_FINAL;
        end else begin
          step_next  = step + 3'd1;
          state_next = S_LOAD;
        end
      end
      S_FINAL: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_src   = uop.src;
    cmd.mul_shift = uop.shift;
    cmd.alu_op    = uop.alu;
    cmd.mul_phase = phase;
    unique case (state)
      S_IDLE:  cmd.accept   = in_valid;
      S_DIV:   cmd.sc_load  = stat.div_done;
      S_LOAD:  cmd.mul_load = 1'b1;
      S_RUN:   cmd.mul_run  = 1'b1;
      S_ALU:   cmd.alu_en   = 1'b1;
      S_FINAL: cmd.out_load = stat.out_free;
      default: cmd          = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/baro_dp.sv =====
// Datapath: restoring divider, shared 32x32 multiplier, saturating adder, output register.
// Depends on baro_pkg; sequenced by baro_ctrl through ctl_cmd_t.
`default_nettype none

module baro_dp #(
  parameter int FRAC_BITS     = 24,
  parameter int OUT_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire baro_pkg::coef_t    coefs,
  input  wire logic [22:0]        temp_scale,
  input  wire logic [22:0]        pres_scale,
  input  wire baro_pkg::in_beat_t in_data,
  input  wire baro_pkg::ctl_cmd_t cmd,
  input  wire logic               out_stall,
  output      baro_pkg::dp_stat_t stat,
  output      logic               out_valid,
  output      baro_pkg::out_beat_t out_data
);
  import baro_pkg::*;

  localparam int DW  = 24 + FRAC_BITS;
  localparam int CW  = $clog2(DW + 1);
  localparam int SHR = (FRAC_BITS > OUT_FRAC_BITS) ? FRAC_BITS - OUT_FRAC_BITS : 0;
  localparam int SHL = (OUT_FRAC_BITS > FRAC_BITS) ? OUT_FRAC_BITS - FRAC_BITS : 0;
  localparam logic [DW-1:0] Q_MAX_POS = DW'(64'd2147483647);
  localparam logic [DW-1:0] Q_MAX_NEG = DW'(64'd2147483648);
  localparam logic [71:0]   O_MAX_POS = 72'h7FFF_FFFF_FFFF;
  localparam logic [71:0]   O_MAX_NEG = 72'h8000_0000_0000;

  // Divider.
  logic [DW-1:0] dq;
  logic [22:0]   rem;
  logic [22:0]   dv;
  logic [CW-1:0] dcnt;
  logic          s_neg, s_zero, op_r;
  logic [23:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] quo;
  logic          div_clip;
  logic signed [31:0] sc_val;

  // Working registers.
  logic signed [31:0] sc, st;
  logic signed [47:0] tpt;
  logic signed [63:0] p, x;
  logic               sat;

  // Multiplier.
  logic [63:0]  ua, ub;
  logic         mneg;
  logic [127:0] acc;
  logic signed [63:0] op_a, op_b;
  logic [31:0]  a_h, b_h;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] mmag;
  logic         m_clip;
  logic [62:0]  mval;
  logic signed [63:0] mres;

  // Adder.
  logic signed [63:0] add_a, add_b, sum, sum_c;
  logic               add_en, add_clip;

  // Output conversion.
  logic [63:0] pmag;
  logic [71:0] omag;
  logic        o_clip;
  logic signed [47:0] oval;

  assign stat.div_done = (dcnt == '0);
  assign stat.out_free = !out_valid || !out_stall;

  assign rem_sh = {1'b0, rem} << 1 | 24'(dq[DW-1]);
  assign ge     = (rem_sh >= {1'b0, dv});

  always_comb begin
    quo = s_zero ? '0 : dq;
    if (s_neg) begin
      div_clip = (quo > Q_MAX_NEG);
      sc_val   = div_clip ? -32'sd2147483647 - 32'sd1 : -$signed(quo[31:0]);
    end else begin
      div_clip = (quo > Q_MAX_POS);
      sc_val   = div_clip ? 32'sd2147483647 : $signed(quo[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.accept) begin
      dcnt <= CW'(DW);
    end else if (dcnt != '0) begin
      dcnt <= dcnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dq     <= {(in_data.raw_sample[23] ? 24'(-in_data.raw_sample) : 24'(in_data.raw_sample)),
                 {FRAC_BITS{1'b0}}};
      rem    <= '0;
      dv     <= (in_data.op == OP_PRES) ? pres_scale : temp_scale;
      s_neg  <= in_data.raw_sample[23];
      s_zero <= (in_data.raw_sample == '0);
      op_r   <= in_data.op;
    end else if (dcnt != '0) begin
      rem <= ge ? 23'(rem_sh - {1'b0, dv}) : rem_sh[22:0];
      dq  <= {dq[DW-2:0], ge};
    end
  end

  // Operand selection for the multiplier.
  always_comb begin
    unique case (cmd.mul_src)
      MS_C30_SC: begin op_a = 64'(coefs.c30); op_b = 64'(sc); end
      MS_SC_P:   begin op_a = 64'(sc);        op_b = p;       end
      MS_C21_SC: begin op_a = 64'(coefs.c21); op_b = 64'(sc); end
      MS_ST_SC:  begin op_a = 64'(st);        op_b = 64'(sc); end
      MS_M_X:    begin op_a = mres;           op_b = x;       end
      MS_C01_SC: begin op_a = 64'(coefs.c01); op_b = 64'(sc); end
      MS_C1_SC:  begin op_a = 64'(coefs.c1);  op_b = 64'(sc); end
      default:   begin op_a = '0;             op_b = '0;      end
    endcase
  end

  assign a_h = cmd.mul_phase[1] ? ua[63:32] : ua[31:0];
  assign b_h = cmd.mul_phase[0] ? ub[63:32] : ub[31:0];
  assign pp  = 64'(a_h) * 64'(b_h);

  always_comb begin
    unique case (cmd.mul_phase)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      ua   <= op_a[63] ? 64'(-op_a) : 64'(op_a);
      ub   <= op_b[63] ? 64'(-op_b) : 64'(op_b);
      mneg <= op_a[63] != op_b[63];
      acc  <= '0;
    end else if (cmd.mul_run) begin
      acc <= acc + pp_sh;
    end
  end

  // Rescale (when mul_shift is set) and clip the finished product.
  always_comb begin
    mmag   = cmd.mul_shift ? (acc >> FRAC_BITS) : acc;
    m_clip = (mmag > 128'(ACC_LIM));
    mval   = m_clip ? 63'(ACC_LIM) : mmag[62:0];
    mres   = mneg ? -$signed(64'(mval)) : $signed(64'(mval));
  end

  always_comb begin
    add_en = 1'b1;
    add_a  = '0;
    add_b  = mres;
    unique case (cmd.alu_op)
      AL_P_C0:      add_a = 64'(coefs.c0) <<< (FRAC_BITS - 1);
      AL_P_C20:     add_a = 64'(coefs.c20) <<< FRAC_BITS;
      AL_P_C10:     add_a = 64'(coefs.c10) <<< FRAC_BITS;
      AL_P_C00:     add_a = 64'(coefs.c00) <<< FRAC_BITS;
      AL_X_C11:     add_a = 64'(coefs.c11) <<< FRAC_BITS;
      AL_P_TPT_X_M: begin add_a = p; add_b = 64'(tpt); end
      AL_P_X:       begin add_a = p; add_b = x;        end
      default:      add_en = 1'b0;
    endcase
    sum = add_a + add_b;
    if (sum > ACC_LIM) begin
      sum_c    = ACC_LIM;
      add_clip = 1'b1;
    end else if (sum < -ACC_LIM) begin
      sum_c    = -ACC_LIM;
      add_clip = 1'b1;
    end else begin
      sum_c    = sum;
      add_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '0;
      tpt <= '0;
    end else begin
      if (cmd.sc_load && op_r == OP_TEMP) begin
        st <= sc_val;
      end
      if (cmd.alu_en && cmd.alu_op == AL_TPT) begin
        tpt <= mres[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sat <= 1'b0;
    end else if (cmd.sc_load) begin
      sat <= sat | div_clip;
    end else if (cmd.alu_en) begin
      sat <= sat | (add_en & add_clip) | ((cmd.mul_src != MS_NONE) & m_clip);
    end
    if (cmd.sc_load) begin
      sc <= sc_val;
    end
    if (cmd.alu_en) begin
      unique case (cmd.alu_op)
        AL_P_C0, AL_P_C20, AL_P_C10, AL_P_C00, AL_P_X: p <= sum_c;
        AL_X_C11:     x <= sum_c;
        AL_P_TPT_X_M: begin p <= sum_c; x <= mres; end
        default:      p <= p;
      endcase
    end
  end

  // Final rescale to the output format and clip to 48 bits.
  always_comb begin
    pmag = p[63] ? 64'(-p) : 64'(p);
    omag = (72'(pmag) >> SHR) << SHL;
    if (p[63]) begin
      o_clip = (omag > O_MAX_NEG);
      oval   = o_clip ? $signed(O_MAX_NEG[47:0]) : -$signed(omag[47:0]);
    end else begin
      o_clip = (omag > O_MAX_POS);
      oval   = o_clip ? $signed(O_MAX_POS[47:0]) : $signed(omag[47:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.result_kind       <= op_r;
      out_data.compensated_value <= oval;
      out_data.saturated         <= sat | o_clip;
    end
  end

endmodule

`default_nettype wire

// ===== sv/baro_sensor_compensation_top.sv =====
// Barometric sensor compensation: raw temperature/pressure samples in, calibrated values out.
//
// Input channel in_valid/in_stall/in_data carries one raw sample per beat, tagged as
// temperature or pressure. Output channel out_valid/out_stall/out_data carries one
// compensated Q-format value per input beat, with a flag set when any clipping occurred.
// Calibration bytes and the two scale factors sit in 64-bit APB registers at 8*index.
// Each sample first passes a restoring divider, one quotient bit per cycle; then a shared
// 32x32 multiplier works through the polynomial, building each product from partial
// products of 32-bit halves. One sample is in flight at a time; in_stall is high after
// acceptance until the result has moved into the output register, so the next sample
// can enter while that result still waits. If the receiver stalls, the result holds and
// the block waits with its next result until the output register frees.
// Reset clears the control state, the stored temperature terms (pressure before any
// temperature uses zero) and loads the default scale factors.
`default_nettype none

module baro_sensor_compensation_top #(
  parameter int FRAC_BITS     = 24,
  parameter int OUT_FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire baro_pkg::in_beat_t              in_data,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      baro_pkg::out_beat_t             out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [baro_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [baro_pkg::PDATA_W-1:0]    pwdata,
  output      logic [baro_pkg::PDATA_W-1:0]    prdata,
  output      logic                            pready
);
  import baro_pkg::*;

  logic [63:0] coef_low, coef_mid;
  logic [15:0] coef_high;
  logic [22:0] temp_scale, pres_scale;
  logic [2:0]  reg_idx;
  logic        wr_en;
  coef_t       coefs;
  ctl_cmd_t    cmd;
  dp_stat_t    stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;
  assign coefs   = baro_coefs(coef_low, coef_mid, coef_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_low   <= '0;
      coef_mid   <= '0;
      coef_high  <= '0;
      temp_scale <= SCALE_RESET;
      pres_scale <= SCALE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_COEF_LOW:  coef_low   <= pwdata;
        REG_COEF_MID:  coef_mid   <= pwdata;
        REG_COEF_HIGH: coef_high  <= pwdata[15:0];
        REG_TEMP_SCL:  temp_scale <= pwdata[22:0];
        REG_PRES_SCL:  pres_scale <= pwdata[22:0];
        default:       coef_low   <= coef_low;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COEF_LOW:  prdata = coef_low;
      REG_COEF_MID:  prdata = coef_mid;
      REG_COEF_HIGH: prdata = 64'(coef_high);
      REG_TEMP_SCL:  prdata = 64'(temp_scale);
      REG_PRES_SCL:  prdata = 64'(pres_scale);
      default:       prdata = '0;
    endcase
  end

  baro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  baro_dp #(
    .FRAC_BITS     (FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .coefs      (coefs),
    .temp_scale (temp_scale),
    .pres_scale (pres_scale),
    .in_data    (in_data),
    .cmd        (cmd),
    .out_stall  (out_stall),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/baro_chk.sv =====
// Port-level checker for the barometric compensation block, bound to the top level.
// Depends on baro_pkg and the assertion macros header.
`default_nettype none
`include "baro_sensor_compensation_top_macros.svh"

module baro_chk (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire baro_pkg::out_beat_t out_data
);
  import baro_pkg::*;

  // Only one sample is worked on at a time.
  `BARO_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat did not raise in_stall")

  `BARO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output beat changed")

  // A new result appears only at the end of a computation.
  `BARO_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result appeared with no sample in flight")

endmodule

bind baro_sensor_compensation_top baro_chk u_baro_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
